// File: sv/vn2d_pkg.sv
package vn2d_pkg;

  localparam int DATA_W    = 32;
  localparam int RAD_W     = 64;
  localparam int REM_W     = 35;
  localparam int ROOT_W    = 32;
  localparam int PART_W    = 33;
  localparam int UNIT_W    = 18;
  localparam int TOL_W     = 17;
  localparam int FRAC_DEF  = 16;
  localparam int OUT_W     = 72;
  localparam int ADDR_W    = 3;
  localparam logic [ADDR_W-1:0] REG_TOL = 3'd0;
  localparam logic [TOL_W-1:0]  TOL_RESET = 17'd1;

  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] my;
    logic              nx;
    logic              ny;
  } sqrt_bus_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] len;
    logic [PART_W-1:0] rx;
    logic [PART_W-1:0] ry;
    logic              nx;
    logic              ny;
  } div_bus_t;

endpackage

// File: sv/vn2d_sqrt_cell.sv
module vn2d_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  vn2d_pkg::sqrt_bus_t   din,
  output vn2d_pkg::sqrt_bus_t   dout
);

  logic [vn2d_pkg::REM_W-1:0] rem_sh;
  logic [vn2d_pkg::REM_W-1:0] trial;
  logic                       take;
  vn2d_pkg::sqrt_bus_t        dout_next;

  always_comb begin
    rem_sh = {din.rem[vn2d_pkg::REM_W-3:0], din.rad[vn2d_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, din.root, 2'b01};
    take   = rem_sh >= trial;
    dout_next       = din;
    dout_next.rad   = {din.rad[vn2d_pkg::RAD_W-3:0], 2'b00};
    dout_next.rem   = take ? rem_sh - trial : rem_sh;
    dout_next.root  = {din.root[vn2d_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.rad  <= dout_next.rad;
      dout.rem  <= dout_next.rem;
      dout.root <= dout_next.root;
      dout.mx   <= dout_next.mx;
      dout.my   <= dout_next.my;
      dout.nx   <= dout_next.nx;
      dout.ny   <= dout_next.ny;
    end
  end

endmodule

// File: sv/vn2d_div_cell.sv
module vn2d_div_cell #(
  parameter int QW = vn2d_pkg::FRAC_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  vn2d_pkg::div_bus_t   din,
  input  logic [QW-1:0]        qx_in,
  input  logic [QW-1:0]        qy_in,
  output vn2d_pkg::div_bus_t   dout,
  output logic [QW-1:0]        qx,
  output logic [QW-1:0]        qy
);

  logic [vn2d_pkg::PART_W-1:0] lenx;
  logic [vn2d_pkg::PART_W-1:0] sx;
  logic [vn2d_pkg::PART_W-1:0] sy;
  logic                        bx;
  logic                        by;

  always_comb begin
    lenx = {1'b0, din.len};
    bx   = din.rx >= lenx;
    by   = din.ry >= lenx;
    sx   = bx ? din.rx - lenx : din.rx;
    sy   = by ? din.ry - lenx : din.ry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.len <= din.len;
      dout.nx  <= din.nx;
      dout.ny  <= din.ny;
      dout.rx  <= {sx[vn2d_pkg::PART_W-2:0], 1'b0};
      dout.ry  <= {sy[vn2d_pkg::PART_W-2:0], 1'b0};
      qx       <= {qx_in[QW-2:0], bx};
      qy       <= {qy_in[QW-2:0], by};
    end
  end

endmodule

// File: sv/vector_normalize_2d.sv
// 2D vector normalizer.
// Slave stream: s_tdata = {vec_y, vec_x}, one request per vector.
// Master stream: m_tdata = {pad, was_zero, length, unit_y, unit_x}.
// length is the floor of sqrt(x^2 + y^2) in Q16.16; unit_x and unit_y are
// the components divided by length, truncated toward zero, in Q1.16.
// A length below zero_tolerance (or exactly zero) yields (1,0), was_zero=1.
// Config: APB register zero_tolerance at address 0 (aliased at 0-3), reset value 1.
// Throughput: one vector per cycle while the receiver keeps m_tready high.
// Pipeline: 3 + 32 + (FRAC_BITS + 1) + 1 register stages, namely a magnitude
// stage, a multiply stage, an add stage, one square-root cell per root bit,
// one divide cell per quotient bit and the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stalled receiver holds every stage and drops s_tready.
// Reset clears all valid flags and restores zero_tolerance to 1.
module vector_normalize_2d (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,  // vec_x, vec_y
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vn2d_pkg::OUT_W-1:0]    m_tdata,  // unit_x, unit_y, length, was_zero
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vn2d_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int FRAC_BITS = vn2d_pkg::FRAC_DEF;
  localparam int QW = FRAC_BITS + 1;
  localparam int NS = vn2d_pkg::ROOT_W;

  logic                          en;
  logic [vn2d_pkg::TOL_W-1:0]    zero_tolerance;

  logic                          v0, v1;
  logic [31:0]                   mx0, my0, mx1, my1;
  logic                          nx0, ny0, nx1, ny1;
  logic [63:0]                   sqx, sqy;
  logic [31:0]                   sx_raw, sy_raw;

  vn2d_pkg::sqrt_bus_t           sq [NS+1];
  vn2d_pkg::div_bus_t            dv [QW+1];
  logic [QW-1:0]                 qxa [QW+1];
  logic [QW-1:0]                 qya [QW+1];

  logic [vn2d_pkg::UNIT_W-1:0]   qx_ext, qy_ext, one_ext;
  logic [vn2d_pkg::UNIT_W-1:0]   ux, uy;
  logic                          zero_len;

  assign pready = 1'b1;
  assign prdata = {{(32 - vn2d_pkg::TOL_W){1'b0}}, zero_tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= vn2d_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == vn2d_pkg::REG_TOL[2]) begin
      zero_tolerance <= pwdata[vn2d_pkg::TOL_W-1:0];
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign sx_raw = s_tdata[31:0];
  assign sy_raw = s_tdata[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      sq[0].valid <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
      sq[0].valid <= v1;
    end
    if (en) begin
      nx0 <= sx_raw[31];
      ny0 <= sy_raw[31];
      mx0 <= sx_raw[31] ? 32'd0 - sx_raw : sx_raw;
      my0 <= sy_raw[31] ? 32'd0 - sy_raw : sy_raw;
      sqx <= {32'd0, mx0} * {32'd0, mx0};
      sqy <= {32'd0, my0} * {32'd0, my0};
      mx1 <= mx0;
      my1 <= my0;
      nx1 <= nx0;
      ny1 <= ny0;
      sq[0].rad  <= sqx + sqy;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].mx   <= mx1;
      sq[0].my   <= my1;
      sq[0].nx   <= nx1;
      sq[0].ny   <= ny1;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    vn2d_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sq[i]),
      .dout (sq[i+1])
    );
  end

  always_comb begin
    dv[0].valid = sq[NS].valid;
    dv[0].len   = sq[NS].root;
    dv[0].rx    = {1'b0, sq[NS].mx};
    dv[0].ry    = {1'b0, sq[NS].my};
    dv[0].nx    = sq[NS].nx;
    dv[0].ny    = sq[NS].ny;
  end

  assign qxa[0] = '0;
  assign qya[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    vn2d_div_cell #(.QW(QW)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .din   (dv[j]),
      .qx_in (qxa[j]),
      .qy_in (qya[j]),
      .dout  (dv[j+1]),
      .qx    (qxa[j+1]),
      .qy    (qya[j+1])
    );
  end

  always_comb begin
    qx_ext   = {{(vn2d_pkg::UNIT_W - QW){1'b0}}, qxa[QW]};
    qy_ext   = {{(vn2d_pkg::UNIT_W - QW){1'b0}}, qya[QW]};
    one_ext  = {{(vn2d_pkg::UNIT_W - 1){1'b0}}, 1'b1} << FRAC_BITS;
    zero_len = (dv[QW].len < {{(32 - vn2d_pkg::TOL_W){1'b0}}, zero_tolerance})
               || (dv[QW].len == '0);
    if (zero_len) begin
      ux = one_ext;
      uy = '0;
    end else begin
      ux = dv[QW].nx ? -qx_ext : qx_ext;
      uy = dv[QW].ny ? -qy_ext : qy_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[QW].valid;
    end
    if (en) begin
      m_tdata <= {3'b000, zero_len, dv[QW].len, uy, ux};
    end
  end

  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[68]) |-> (m_tdata[35:18] == '0))
    else $error("zero vector without default unit");

  a_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[68]) |-> (m_tdata[67:36] != '0))
    else $error("division by zero length");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
